// ----- rtl/core/lrc_pkg.sv -----
// lrc_pkg: shared constants, register codes, state and queue word types
// for the Lorentzian residual cost block. No dependencies.
`default_nettype none

package lrc_pkg;

    localparam int LRC_FRAC_BITS  = 16;
    localparam int LRC_FIFO_DEPTH = 4;
    localparam int LRC_DATA_W     = 32;
    localparam int LRC_LW_W       = 31;
    localparam int LRC_WIDE_W     = 64;
    localparam int LRC_IDX_W      = 2;

    typedef enum logic [LRC_IDX_W-1:0] {
        REG_OFFSET    = 2'd0,
        REG_AMPLITUDE = 2'd1,
        REG_CENTER    = 2'd2,
        REG_LINEWIDTH = 2'd3
    } lrc_reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_RES,
        ST_SQ,
        ST_ACC
    } lrc_state_t;

    // one classified point, front to back
    typedef struct packed {
        logic [LRC_WIDE_W-1:0] num;
        logic [LRC_WIDE_W-1:0] den;
        logic                  zero;
        logic [LRC_DATA_W-1:0] intensity;
        logic                  last;
    } lrc_work_t;

endpackage

`default_nettype wire

// ----- rtl/core/lrc_front.sv -----
// lrc_front: two-stage front end; forms (f-center)^2 and (linewidth/2)^2,
// picks numerator and denominator of the ratio. Depends on lrc_pkg.
`default_nettype none

module lrc_front
    import lrc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [LRC_DATA_W-1:0] frequency,
    input  wire logic [LRC_DATA_W-1:0] intensity,
    input  wire logic                  last,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [LRC_DATA_W-1:0] center,
    input  wire logic [LRC_LW_W-1:0]   linewidth,
    output lrc_work_t                  work,
    output logic                       work_push,
    input  wire logic                  work_full
);

    logic                  va_reg;
    logic                  vb_reg;
    logic [LRC_DATA_W-1:0] dm_reg;
    logic [LRC_DATA_W-1:0] ya_reg;
    logic                  la_reg;
    logic [LRC_WIDE_W-1:0] d2_reg;
    logic [LRC_WIDE_W-1:0] h2_reg;
    logic [LRC_DATA_W-1:0] yb_reg;
    logic                  lb_reg;

    logic                      advance;
    logic signed [LRC_DATA_W:0] diff;
    logic [LRC_DATA_W:0]       diff_mag;
    logic [2*LRC_LW_W-1:0]     g2;
    logic [LRC_WIDE_W:0]       den_sum;
    logic                      den_ovf;

    assign advance = !(vb_reg && work_full);
    assign full    = !advance;

    assign diff     = $signed({frequency[LRC_DATA_W-1], frequency})
                    - $signed({center[LRC_DATA_W-1], center});
    assign diff_mag = diff[LRC_DATA_W] ? (LRC_DATA_W+1)'(-diff) : (LRC_DATA_W+1)'(diff);
    assign g2       = (2*LRC_LW_W)'(linewidth) * (2*LRC_LW_W)'(linewidth);

    // a sum that leaves 64 bits gets both operands halved
    assign den_sum = {1'b0, d2_reg} + {1'b0, h2_reg};
    assign den_ovf = den_sum[LRC_WIDE_W];

    always_comb
    begin
        work.num       = den_ovf ? (h2_reg >> 1) : h2_reg;
        work.den       = den_ovf ? ((d2_reg >> 1) + (h2_reg >> 1)) : den_sum[LRC_WIDE_W-1:0];
        work.zero      = (d2_reg == '0);
        work.intensity = yb_reg;
        work.last      = lb_reg;
        work_push      = vb_reg && !work_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (advance)
        begin
            va_reg <= push;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dm_reg <= diff_mag[LRC_DATA_W-1:0];
            ya_reg <= intensity;
            la_reg <= last;
            d2_reg <= LRC_WIDE_W'(dm_reg) * LRC_WIDE_W'(dm_reg);
            h2_reg <= LRC_WIDE_W'(g2 >> 2);
            yb_reg <= ya_reg;
            lb_reg <= la_reg;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/lrc_fifo.sv -----
// lrc_fifo: short register queue of classified words between front and back.
// Depends on lrc_pkg.
`default_nettype none

module lrc_fifo
    import lrc_pkg::*;
#(
    parameter int DEPTH = LRC_FIFO_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire lrc_work_t wdata,
    output logic           full,
    input  wire logic      pop,
    output lrc_work_t      rdata,
    output logic           empty
);

    localparam int PTR_W = $clog2(DEPTH);

    lrc_work_t        mem_reg [DEPTH];
    logic [PTR_W:0]   wptr_reg;
    logic [PTR_W:0]   rptr_reg;

    assign empty = (wptr_reg == rptr_reg);
    assign full  = (wptr_reg[PTR_W-1:0] == rptr_reg[PTR_W-1:0])
                && (wptr_reg[PTR_W] != rptr_reg[PTR_W]);
    assign rdata = mem_reg[rptr_reg[PTR_W-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
        end
        else
        begin
            if (push && !full)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop && !empty)
                rptr_reg <= rptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wptr_reg[PTR_W-1:0]] <= wdata;
    end

endmodule

`default_nettype wire

// ----- rtl/core/lrc_back.sv -----
// lrc_back: sequencer for one word at a time: bit-serial ratio divide, model,
// residual square, saturating accumulate and result register. Depends on lrc_pkg.
`default_nettype none

module lrc_back
    import lrc_pkg::*;
#(
    parameter int FRAC_BITS = LRC_FRAC_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lrc_work_t             work,
    input  wire logic                  work_empty,
    output logic                       work_pop,
    input  wire logic [LRC_DATA_W-1:0] offset,
    input  wire logic [LRC_DATA_W-1:0] amplitude,
    output logic [LRC_WIDE_W-1:0]      cost,
    output logic                       saturated,
    output logic                       empty,
    input  wire logic                  pop
);

    localparam int Q_W    = FRAC_BITS + 1;
    localparam int CNT_W  = $clog2(FRAC_BITS);
    localparam int PROD_W = LRC_DATA_W + Q_W + 1;
    localparam int MOD_W  = LRC_DATA_W + 2;
    localparam int RES_W  = LRC_DATA_W + 4;

    lrc_state_t               state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [LRC_WIDE_W-1:0]    sum_reg, sum_next;
    logic                     clip_reg, clip_next;
    logic                     out_valid_reg, out_valid_next;

    logic [LRC_WIDE_W-1:0]    rem_reg, rem_next;
    logic [LRC_WIDE_W-1:0]    den_reg, den_next;
    logic [Q_W-1:0]           q_reg, q_next;
    logic [LRC_DATA_W-1:0]    y_reg, y_next;
    logic                     last_reg, last_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [LRC_DATA_W-1:0]    rm_reg, rm_next;
    logic                     big_reg, big_next;
    logic [LRC_WIDE_W-1:0]    sq_reg, sq_next;
    logic                     sq_clip_reg, sq_clip_next;
    logic [LRC_WIDE_W-1:0]    cost_reg, cost_next;
    logic                     sat_reg, sat_next;

    logic [LRC_WIDE_W-1:0]    rem_sh;
    logic                     take;
    logic signed [PROD_W-1:0] prod_full;
    logic signed [PROD_W-1:0] prod_sh;
    logic signed [MOD_W-1:0]  model;
    logic signed [RES_W-1:0]  res;
    logic [RES_W-1:0]         res_mag;
    logic [LRC_WIDE_W:0]      acc;
    logic [LRC_WIDE_W-1:0]    sum_new;
    logic                     clip_new;

    // restoring divide step; the bit shifted out forces a subtract
    assign rem_sh = {rem_reg[LRC_WIDE_W-2:0], 1'b0};
    assign take   = rem_reg[LRC_WIDE_W-1] || (rem_sh >= den_reg);

    assign prod_full = PROD_W'($signed(amplitude)) * $signed(PROD_W'(q_reg));
    assign prod_sh   = prod_reg >>> FRAC_BITS;
    assign model     = MOD_W'($signed(offset)) + MOD_W'(prod_sh);
    assign res       = RES_W'($signed(y_reg)) - RES_W'(model);
    assign res_mag   = res[RES_W-1] ? RES_W'(-res) : RES_W'(res);

    assign acc      = {1'b0, sum_reg} + {1'b0, sq_reg};
    assign sum_new  = acc[LRC_WIDE_W] ? '1 : acc[LRC_WIDE_W-1:0];
    assign clip_new = clip_reg | sq_clip_reg | acc[LRC_WIDE_W];

    assign cost      = cost_reg;
    assign saturated = sat_reg;
    assign empty     = !out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        clip_next      = clip_reg;
        out_valid_next = out_valid_reg && !pop;
        rem_next       = rem_reg;
        den_next       = den_reg;
        q_next         = q_reg;
        y_next         = y_reg;
        last_next      = last_reg;
        prod_next      = prod_reg;
        rm_next        = rm_reg;
        big_next       = big_reg;
        sq_next        = sq_reg;
        sq_clip_next   = sq_clip_reg;
        cost_next      = cost_reg;
        sat_next       = sat_reg;
        work_pop       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!work_empty)
                begin
                    work_pop  = 1'b1;
                    rem_next  = work.num;
                    den_next  = work.den;
                    y_next    = work.intensity;
                    last_next = work.last;
                    cnt_next  = '0;
                    if (work.zero)
                    begin
                        // zero distance: ratio is exactly one
                        q_next     = Q_W'(1) << FRAC_BITS;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        q_next     = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next = take ? (rem_sh - den_reg) : rem_sh;
                q_next   = {q_reg[Q_W-2:0], take};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(FRAC_BITS - 1))
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = prod_full;
                state_next = ST_RES;
            end
            ST_RES:
            begin
                rm_next    = res_mag[LRC_DATA_W-1:0];
                big_next   = |res_mag[RES_W-1:LRC_DATA_W];
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                sq_next      = big_reg ? '1
                             : LRC_WIDE_W'(rm_reg) * LRC_WIDE_W'(rm_reg);
                sq_clip_next = big_reg;
                state_next   = ST_SQ == state_reg ? ST_ACC : state_reg;
            end
            ST_ACC:
            begin
                if (!last_reg)
                begin
                    sum_next   = sum_new;
                    clip_next  = clip_new;
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || pop)
                begin
                    cost_next      = sum_new;
                    sat_next       = clip_new;
                    out_valid_next = 1'b1;
                    sum_next       = '0;
                    clip_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            clip_reg      <= clip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        den_reg     <= den_next;
        q_reg       <= q_next;
        y_reg       <= y_next;
        last_reg    <= last_next;
        prod_reg    <= prod_next;
        rm_reg      <= rm_next;
        big_reg     <= big_next;
        sq_reg      <= sq_next;
        sq_clip_reg <= sq_clip_next;
        cost_reg    <= cost_next;
        sat_reg     <= sat_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/lorentzian_residual_cost_top.sv -----
// Lorentzian residual cost: one point in, the squared-residual sum out on last.
// Path: the two front stages and the queue, then the back sequencer (which skips
// the divide when frequency equals center). The back end takes one point at a time,
// only after the last one is done; the bit-serial ratio divider sets its pace.
// Reset (rst_n low, asynchronous) empties the queue and clears sum and clip flag;
// registers return to offset 0, amplitude 1.0, center 0, linewidth 1.0.
`default_nettype none

module lorentzian_residual_cost_top
    import lrc_pkg::*;
#(
    parameter int FRAC_BITS  = LRC_FRAC_BITS,
    parameter int FIFO_DEPTH = LRC_FIFO_DEPTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [LRC_IDX_W-1:0]  cfg_index,
    input  wire logic [LRC_DATA_W-1:0] cfg_data,
    input  wire logic [LRC_DATA_W-1:0] frequency,
    input  wire logic [LRC_DATA_W-1:0] intensity,
    input  wire logic                  last,
    input  wire logic                  push,
    output logic                       full,
    output logic [LRC_WIDE_W-1:0]      cost,
    output logic                       saturated,
    output logic                       empty,
    input  wire logic                  pop
);

    logic [LRC_DATA_W-1:0] offset_reg;
    logic [LRC_DATA_W-1:0] amplitude_reg;
    logic [LRC_DATA_W-1:0] center_reg;
    logic [LRC_LW_W-1:0]   linewidth_reg;

    lrc_work_t front_word;
    lrc_work_t back_word;
    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            amplitude_reg <= LRC_DATA_W'(1) << FRAC_BITS;
            center_reg    <= '0;
            linewidth_reg <= LRC_LW_W'(1) << FRAC_BITS;
        end
        else if (cfg_write)
        begin
            unique case (lrc_reg_idx_t'(cfg_index))
                REG_OFFSET:    offset_reg    <= cfg_data;
                REG_AMPLITUDE: amplitude_reg <= cfg_data;
                REG_CENTER:    center_reg    <= cfg_data;
                REG_LINEWIDTH: linewidth_reg <= cfg_data[LRC_LW_W-1:0];
            endcase
        end
    end

    lrc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .frequency (frequency),
        .intensity (intensity),
        .last      (last),
        .push      (push),
        .full      (full),
        .center    (center_reg),
        .linewidth (linewidth_reg),
        .work      (front_word),
        .work_push (q_push),
        .work_full (q_full)
    );

    lrc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (front_word),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (back_word),
        .empty (q_empty)
    );

    lrc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .work       (back_word),
        .work_empty (q_empty),
        .work_pop   (q_pop),
        .offset     (offset_reg),
        .amplitude  (amplitude_reg),
        .cost       (cost),
        .saturated  (saturated),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

`default_nettype wire
